### sv/gtl_pkg.sv
// ----------------------------------------------------------------------------
// gtl_pkg
// Shared widths, character codes, register indexes and helpers for the grid
// text loader.
// ----------------------------------------------------------------------------
package gtl_pkg;

   localparam int unsigned COORD_W = 32;
   localparam int unsigned COUNT_W = 31;
   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned CSR_IDX_W = 2;

   typedef logic [COUNT_W-1:0] count_type;
   typedef logic [COORD_W-1:0] coord_type;
   typedef logic [BYTE_W-1:0]  byte_type;

   localparam count_type COUNT_MAX = '1;

   localparam byte_type CHAR_FF    = 8'h0C;
   localparam byte_type CHAR_CR    = 8'h0D;
   localparam byte_type CHAR_LF    = 8'h0A;
   localparam byte_type CHAR_SPACE = 8'h20;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_OFFSET_X    = 2'd0,
      CSR_OFFSET_Y    = 2'd1,
      CSR_BINARY_MODE = 2'd2,
      CSR_UNUSED      = 2'd3
   } csr_index_type;

   function automatic count_type sat_inc(input count_type v);
      return (v == COUNT_MAX) ? COUNT_MAX : count_type'(v + count_type'(1));
   endfunction

   function automatic count_type count_max(input count_type a, input count_type b);
      return (a > b) ? a : b;
   endfunction

endpackage

### sv/gtl_if.sv
// ----------------------------------------------------------------------------
// gtl_req_if / gtl_rsp_if
// Valid/ready channels for the byte requests and the loader results.
// ----------------------------------------------------------------------------
interface gtl_req_if;
   logic                 valid;
   logic                 ready;
   gtl_pkg::byte_type    data_byte;
   logic                 final_byte;

   modport source (output valid, output data_byte, output final_byte, input ready);
   modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

interface gtl_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 is_write;
   logic signed [gtl_pkg::COORD_W-1:0]   cell_x;
   logic signed [gtl_pkg::COORD_W-1:0]   cell_y;
   gtl_pkg::byte_type                    cell_value;
   gtl_pkg::count_type                   size_x;
   gtl_pkg::count_type                   size_y;
   logic                                 last;

   modport source (output valid, output is_write, output cell_x, output cell_y,
                   output cell_value, output size_x, output size_y, output last,
                   input ready);
   modport sink   (input valid, input is_write, input cell_x, input cell_y,
                   input cell_value, input size_x, input size_y, input last,
                   output ready);
endinterface

### sv/grid_text_loader_at_offset.sv
// ----------------------------------------------------------------------------
// grid_text_loader_at_offset
// Turns a stream of file bytes into cell writes at a configured grid offset,
// followed by a size report on the final byte.
// ----------------------------------------------------------------------------
// One request (one byte) is taken per cycle while the result channel is
// ready. Each request is decoded combinationally against the column, row,
// widest-line and pending-CR registers and its results are registered in a
// two-entry result register: one slot for a cell write, one for the size
// report. A byte that yields at most one result keeps the full rate; a final
// byte that is also written yields two results and so holds off the next
// request while both leave the result register. Configuration writes are
// taken any time but must only be issued while the loader is idle.
// ----------------------------------------------------------------------------
module grid_text_loader_at_offset (
   input  logic                                  clock,
   input  logic                                  reset,
   gtl_req_if.sink                               req_chan,
   gtl_rsp_if.source                             rsp_chan,
   input  logic                                  csr_write_enable,
   input  logic [gtl_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [gtl_pkg::COORD_W-1:0]           csr_data
);

   // configuration
   gtl_pkg::coord_type  offset_x_ff;
   gtl_pkg::coord_type  offset_y_ff;
   logic                binary_mode_ff;

   // file state
   gtl_pkg::count_type  column_ff, column_in;
   gtl_pkg::count_type  row_ff, row_in;
   gtl_pkg::count_type  widest_ff, widest_in;
   logic                cr_pending_ff, cr_pending_in;

   // result slots
   logic                wr_valid_ff, wr_valid_in;
   gtl_pkg::coord_type  wr_x_ff, wr_x_in;
   gtl_pkg::coord_type  wr_y_ff, wr_y_in;
   gtl_pkg::byte_type   wr_value_ff, wr_value_in;
   logic                rep_valid_ff, rep_valid_in;
   gtl_pkg::count_type  rep_x_ff, rep_x_in;
   gtl_pkg::count_type  rep_y_ff, rep_y_in;

   // decode
   gtl_pkg::byte_type   data;
   logic                is_ff, is_cr, is_lf, is_other;
   logic                do_end, advance, emit_write;
   gtl_pkg::count_type  col_e, row_e, wid_e, col_n;
   logic                cr_n;

   logic                req_fire, rsp_fire;

   assign req_fire = req_chan.valid && req_chan.ready;
   assign rsp_fire = rsp_chan.valid && rsp_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_x_ff    <= '0;
         offset_y_ff    <= '0;
         binary_mode_ff <= 1'b0;
      end else if (csr_write_enable) begin
         unique case (gtl_pkg::csr_index_type'(csr_index))
            gtl_pkg::CSR_OFFSET_X:    offset_x_ff    <= csr_data;
            gtl_pkg::CSR_OFFSET_Y:    offset_y_ff    <= csr_data;
            gtl_pkg::CSR_BINARY_MODE: binary_mode_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      data     = req_chan.data_byte;
      is_ff    = !binary_mode_ff && (data == gtl_pkg::CHAR_FF);
      is_cr    = !binary_mode_ff && (data == gtl_pkg::CHAR_CR);
      is_lf    = !binary_mode_ff && (data == gtl_pkg::CHAR_LF);
      is_other = !binary_mode_ff && !is_ff && !is_cr && !is_lf;

      do_end  = is_lf || ((is_cr || is_other) && cr_pending_ff);
      col_e   = do_end ? '0 : column_ff;
      row_e   = do_end ? gtl_pkg::sat_inc(row_ff) : row_ff;
      wid_e   = do_end ? gtl_pkg::count_max(column_ff, widest_ff) : widest_ff;

      advance    = binary_mode_ff || is_other;
      emit_write = advance && (data != gtl_pkg::CHAR_SPACE);
      col_n      = advance ? gtl_pkg::sat_inc(col_e) : col_e;

      priority if (binary_mode_ff || is_ff) begin
         cr_n = cr_pending_ff;
      end else if (is_cr) begin
         cr_n = 1'b1;
      end else begin
         cr_n = 1'b0;
      end

      wr_x_in     = gtl_pkg::coord_type'(offset_x_ff + {1'b0, col_e});
      wr_y_in     = binary_mode_ff ? offset_y_ff
                                   : gtl_pkg::coord_type'(offset_y_ff + {1'b0, row_e});
      wr_value_in = data;
      rep_x_in    = gtl_pkg::count_max(col_n, wid_e);
      rep_y_in    = binary_mode_ff ? '0 : (cr_n ? gtl_pkg::sat_inc(row_e) : row_e);

      if (req_chan.final_byte) begin
         column_in     = '0;
         row_in        = '0;
         widest_in     = '0;
         cr_pending_in = 1'b0;
      end else begin
         column_in     = col_n;
         row_in        = row_e;
         widest_in     = wid_e;
         cr_pending_in = cr_n;
      end
   end

   // slot valid bits: the write slot drains first
   always_comb begin
      wr_valid_in  = wr_valid_ff;
      rep_valid_in = rep_valid_ff;
      if (rsp_fire) begin
         if (wr_valid_ff) begin
            wr_valid_in = 1'b0;
         end else begin
            rep_valid_in = 1'b0;
         end
      end
      if (req_fire) begin
         wr_valid_in  = emit_write;
         rep_valid_in = req_chan.final_byte;
      end
   end

   assign req_chan.ready = !(wr_valid_ff || rep_valid_ff) ||
                           ((wr_valid_ff != rep_valid_ff) && rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff     <= '0;
         row_ff        <= '0;
         widest_ff     <= '0;
         cr_pending_ff <= 1'b0;
         wr_valid_ff   <= 1'b0;
         rep_valid_ff  <= 1'b0;
      end else begin
         wr_valid_ff  <= wr_valid_in;
         rep_valid_ff <= rep_valid_in;
         if (req_fire) begin
            column_ff     <= column_in;
            row_ff        <= row_in;
            widest_ff     <= widest_in;
            cr_pending_ff <= cr_pending_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         wr_x_ff     <= wr_x_in;
         wr_y_ff     <= wr_y_in;
         wr_value_ff <= wr_value_in;
         rep_x_ff    <= rep_x_in;
         rep_y_ff    <= rep_y_in;
      end
   end

   always_comb begin
      rsp_chan.valid      = wr_valid_ff || rep_valid_ff;
      rsp_chan.is_write   = wr_valid_ff;
      rsp_chan.last       = !wr_valid_ff;
      rsp_chan.cell_x     = wr_valid_ff ? wr_x_ff : '0;
      rsp_chan.cell_y     = wr_valid_ff ? wr_y_ff : '0;
      rsp_chan.cell_value = wr_valid_ff ? wr_value_ff : '0;
      rsp_chan.size_x     = wr_valid_ff ? '0 : rep_x_ff;
      rsp_chan.size_y     = wr_valid_ff ? '0 : rep_y_ff;
   end

`ifndef SYNTHESIS
   a_no_accept_when_full: assert property (@(posedge clock) disable iff (reset)
      req_fire |-> !(wr_valid_ff && rep_valid_ff))
      else $error("request accepted with both result slots occupied");

   a_report_follows_write: assert property (@(posedge clock) disable iff (reset)
      (rsp_fire && wr_valid_ff && rep_valid_ff) |=> (rep_valid_ff && !wr_valid_ff))
      else $error("size report lost after write drained");

   a_final_clears_state: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_chan.final_byte) |=>
         (column_ff == '0 && row_ff == '0 && widest_ff == '0 && !cr_pending_ff))
      else $error("file state not cleared after final byte");

   a_final_gives_report: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_chan.final_byte) |=> rep_valid_ff)
      else $error("final byte did not produce a size report");
`endif

endmodule
